>>> design/cmbe_pkg.sv
// ----------------------------------------------------------------------------
// cmbe_pkg: shared types and constants of the clipped mask blit expander
// Field widths, register indexes and the control structs used between units.
// ----------------------------------------------------------------------------
package cmbe_pkg;

  localparam int unsigned MASK_BYTES_DEF = 4096;

  // field widths
  localparam int KIND_W   = 1;
  localparam int MADDR_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int ORG_W    = 11;
  localparam int FRAME_W  = 8;
  localparam int ROW_W    = 6;
  localparam int BLK_W    = 3;
  localparam int COLOR_W  = 8;
  localparam int SCR_W    = 10;
  localparam int SPR_W    = 7;
  localparam int STRIDE_W = 5;
  localparam int POS_W    = ORG_W + 1;
  localparam int COL_W    = BLK_W + 3;
  localparam int BIT_CNT_W = 3;

  // (frame * height + row) * stride + block fits in 20 bits
  localparam int IDX_W     = 20;
  localparam int IDX_CNT_W = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCR_W;

  localparam logic [SCR_W-1:0] SCR_W_RST = SCR_W'(320);
  localparam logic [SCR_W-1:0] SCR_H_RST = SCR_W'(240);
  localparam logic [SPR_W-1:0] SPR_W_RST = SPR_W'(16);
  localparam logic [SPR_W-1:0] SPR_H_RST = SPR_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_SPRITE_WIDTH  = 2'd2,
    CFG_SPRITE_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // address sequencer control
  typedef struct packed {
    logic start;
    logic draw;
  } cmbe_ad_ctl_t;

  // pixel scan command
  typedef struct packed {
    logic               start;
    logic [BYTE_W-1:0]  bits;
    logic [COL_W-1:0]   col0;
    logic [POS_W-1:0]   x0;
    logic [SCR_W-1:0]   y;
    logic [COLOR_W-1:0] color;
  } cmbe_em_cmd_t;

  typedef struct packed {
    logic busy;
  } cmbe_em_stat_t;

endpackage

>>> design/cmbe_if.sv
// ----------------------------------------------------------------------------
// cmbe_if: valid/ready channels of the clipped mask blit expander
// Input item channel and pixel write channel.
// ----------------------------------------------------------------------------
interface cmbe_in_if
  import cmbe_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [MADDR_W-1:0]       mask_address;
  logic [BYTE_W-1:0]        mask_byte;
  logic signed [ORG_W-1:0]  origin_x;
  logic signed [ORG_W-1:0]  origin_y;
  logic [FRAME_W-1:0]       frame_index;
  logic [ROW_W-1:0]         sprite_row;
  logic [BLK_W-1:0]         byte_block;
  logic [COLOR_W-1:0]       paint_color;

  modport source (
    output valid, kind, mask_address, mask_byte, origin_x, origin_y,
           frame_index, sprite_row, byte_block, paint_color,
    input  ready
  );
  modport sink (
    input  valid, kind, mask_address, mask_byte, origin_x, origin_y,
           frame_index, sprite_row, byte_block, paint_color,
    output ready
  );
endinterface

interface cmbe_out_if
  import cmbe_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SCR_W-1:0]   pixel_x;
  logic [SCR_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

>>> design/cmbe_addr_seq.sv
// ----------------------------------------------------------------------------
// cmbe_addr_seq: serial mask address sequencer
// Draws: shift-add multiplies one multiplier bit per cycle. Both kinds then
// reduce the index modulo the store size one index bit per cycle (MSB first).
// ----------------------------------------------------------------------------
module cmbe_addr_seq
  import cmbe_pkg::*;
#(
  parameter int unsigned MASK_BYTES = MASK_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmbe_ad_ctl_t         ctl,
  input  logic [FRAME_W-1:0]   frame_i,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [BLK_W-1:0]     block_i,
  input  logic [MADDR_W-1:0]   maddr_i,
  input  logic [SPR_W-1:0]     sh_i,
  input  logic [STRIDE_W-1:0]  stride_i,
  output logic [$clog2(MASK_BYTES)-1:0] addr_o,
  output logic                 done_o
);

  localparam int AW = $clog2(MASK_BYTES);
  localparam logic [AW:0] MOD_K = (AW+1)'(MASK_BYTES);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL1 = 4'b0010,
    A_MUL2 = 4'b0100,
    A_MOD  = 4'b1000
  } aseq_state_t;

  aseq_state_t          st_r, st_nxt;
  logic [IDX_W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0]     mcand_r, mcand_nxt;
  logic [SPR_W-1:0]     mplier_r, mplier_nxt;
  logic [IDX_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]        rem_r, rem_nxt;
  logic                 done_r, done_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [BLK_W-1:0]     block_r, block_nxt;

  logic [IDX_W-1:0]     acc_add;
  logic [AW:0]          rem_sh;

  assign acc_add = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign rem_sh  = {rem_r, mcand_r[IDX_W-1]};

  always_comb begin
    st_nxt     = st_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    done_nxt   = 1'b0;
    row_nxt    = row_r;
    block_nxt  = block_r;
    case (st_r)
      A_IDLE: begin
        if (ctl.start) begin
          if (ctl.draw) begin
            acc_nxt    = '0;
            mcand_nxt  = IDX_W'(frame_i);
            mplier_nxt = sh_i;
            row_nxt    = row_i;
            block_nxt  = block_i;
            st_nxt     = A_MUL1;
          end else begin
            mcand_nxt = IDX_W'(maddr_i);
            rem_nxt   = '0;
            cnt_nxt   = IDX_CNT_W'(IDX_W - 1);
            st_nxt    = A_MOD;
          end
        end
      end
      A_MUL1, A_MUL2: begin
        if (mplier_r == '0) begin
          acc_nxt = '0;
          if (st_r == A_MUL1) begin
            mcand_nxt  = acc_r + IDX_W'(row_r);
            mplier_nxt = SPR_W'(stride_i);
            st_nxt     = A_MUL2;
          end else begin
            mcand_nxt = acc_r + IDX_W'(block_r);
            rem_nxt   = '0;
            cnt_nxt   = IDX_CNT_W'(IDX_W - 1);
            st_nxt    = A_MOD;
          end
        end else begin
          acc_nxt    = acc_add;
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      A_MOD: begin
        // remainder stays below the store size, so one subtract suffices
        if (rem_sh >= MOD_K) begin
          rem_nxt = AW'(rem_sh - MOD_K);
        end else begin
          rem_nxt = rem_sh[AW-1:0];
        end
        mcand_nxt = mcand_r << 1;
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    row_r    <= row_nxt;
    block_r  <= block_nxt;
  end

  assign addr_o = rem_r;
  assign done_o = done_r;

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rem_r} < MOD_K))
    else $error("address remainder not below store size");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (st_r == A_IDLE))
    else $error("address done while sequencer still running");

endmodule

>>> design/cmbe_pix_emit.sv
// ----------------------------------------------------------------------------
// cmbe_pix_emit: bit-serial pixel qualifier and emitter
// First pass shifts the mask byte through the clip tests one bit a cycle;
// second pass walks the qualified bits and sends one pixel beat per set bit.
// ----------------------------------------------------------------------------
module cmbe_pix_emit
  import cmbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmbe_em_cmd_t      cmd,
  input  logic [SPR_W-1:0]  sw_i,
  input  logic [SCR_W-1:0]  scr_w_i,
  output cmbe_em_stat_t     stat,
  cmbe_out_if.source        out_bus
);

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_QUAL = 3'b010,
    P_EMIT = 3'b100
  } pemit_state_t;

  pemit_state_t           st_r, st_nxt;
  logic [BYTE_W-1:0]      bits_r, bits_nxt;
  logic [BYTE_W-1:0]      qual_r, qual_nxt;
  logic [POS_W-1:0]       x_r, x_nxt;
  logic [POS_W-1:0]       x0_r, x0_nxt;
  logic [SPR_W-1:0]       col_r, col_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SCR_W-1:0]       y_r, y_nxt;
  logic [COLOR_W-1:0]     color_r, color_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SCR_W-1:0]       out_x_r, out_x_nxt;
  logic [SCR_W-1:0]       out_y_r, out_y_nxt;
  logic [COLOR_W-1:0]     out_color_r, out_color_nxt;
  logic                   out_last_r, out_last_nxt;

  logic hit;
  logic out_free;

  // one bit: set, inside sprite width, on screen horizontally
  assign hit = bits_r[0] && (col_r < sw_i) && !x_r[POS_W-1]
               && (x_r[POS_W-2:0] < {1'b0, scr_w_i});
  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    st_nxt        = st_r;
    bits_nxt      = bits_r;
    qual_nxt      = qual_r;
    x_nxt         = x_r;
    x0_nxt        = x0_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    y_nxt         = y_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    case (st_r)
      P_IDLE: begin
        if (cmd.start) begin
          bits_nxt  = cmd.bits;
          qual_nxt  = '0;
          x_nxt     = cmd.x0;
          x0_nxt    = cmd.x0;
          col_nxt   = SPR_W'(cmd.col0);
          cnt_nxt   = '0;
          y_nxt     = cmd.y;
          color_nxt = cmd.color;
          st_nxt    = P_QUAL;
        end
      end
      P_QUAL: begin
        qual_nxt = {hit, qual_r[BYTE_W-1:1]};
        bits_nxt = bits_r >> 1;
        col_nxt  = col_r + 1'b1;
        x_nxt    = x_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          x_nxt  = x0_r;
          st_nxt = P_EMIT;
        end
      end
      P_EMIT: begin
        if (qual_r == '0) begin
          st_nxt = P_IDLE;
        end else if (!qual_r[0]) begin
          qual_nxt = qual_r >> 1;
          x_nxt    = x_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_r[SCR_W-1:0];
          out_y_nxt     = y_r;
          out_color_nxt = color_r;
          out_last_nxt  = (qual_r[BYTE_W-1:1] == '0);
          qual_nxt      = qual_r >> 1;
          x_nxt         = x_r + 1'b1;
        end
      end
      default: st_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= P_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    qual_r      <= qual_nxt;
    x_r         <= x_nxt;
    x0_r        <= x0_nxt;
    col_r       <= col_nxt;
    cnt_r       <= cnt_nxt;
    y_r         <= y_nxt;
    color_r     <= color_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign stat.busy           = (st_r != P_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.pixel_x     = out_x_r;
  assign out_bus.pixel_y     = out_y_r;
  assign out_bus.pixel_color = out_color_r;
  assign out_bus.last        = out_last_r;

  a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (st_r == P_EMIT))
    else $error("non-last pixel pending with no pixels left to scan");

endmodule

>>> design/clipped_mask_blit_expander_unit.sv
// ----------------------------------------------------------------------------
// clipped_mask_blit_expander_unit: 1bpp sprite mask store and clipped blitter
// Load beats fill the mask store; draw beats expand one mask byte into
// clipped pixel write beats, LSB first, last flag on the final one.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  in_bus    in   valid/ready       kind, mask_address, mask_byte, origin_x/y,
//                                   frame_index, sprite_row, byte_block, color
//  out_bus   out  valid/ready       pixel_x, pixel_y, pixel_color, last
//  cfg_*     in   cfg_we only       cfg_index, cfg_data (no read-back)
//
//  Sequencing: one beat at a time. Load: accept, serial modulo over the 20
//  index bits, write. Draw: accept, shift-add multiply by sprite_height, add
//  row, multiply by stride, add block, serial modulo, store read, qualify
//  the 8 mask bits, then emit set bits until the highest qualified one.
//  A draw failing the empty/row/block/line checks retires in its accept cycle.
//  Cost is set by the shift-add multiplier, the MSB-first modulo reducer and
//  the pixel scan, one bit per cycle save for output stalls.
//  Reset: synchronous rst_n, clears control and config to defaults; mask
//  store contents stay undefined until loaded.
//  Stalls: out_bus.ready low holds the scan at its next set bit; a finished
//  last beat waits in the output register while the next input beat is taken.
//
module clipped_mask_blit_expander_unit
  import cmbe_pkg::*;
#(
  parameter int unsigned MASK_BYTES = MASK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cmbe_in_if.sink               in_bus,
  cmbe_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MASK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_READ = 4'b0100,
    S_EMIT = 4'b1000
  } top_state_t;

  // config registers
  logic [SCR_W-1:0]    scr_w_r, scr_h_r;
  logic [SPR_W-1:0]    spr_w_r, spr_h_r;

  top_state_t          state_r, state_nxt;
  logic                kind_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [SCR_W-1:0]    y_r;
  logic [POS_W-1:0]    x0_r;
  logic [COL_W-1:0]    col0_r;
  logic [COLOR_W-1:0]  color_r;
  logic [BYTE_W-1:0]   rd_byte_r;

  logic [BYTE_W-1:0]   mask_mem [MASK_BYTES];

  logic [SPR_W:0]      stride_sum;
  logic [STRIDE_W-1:0] stride;
  logic [POS_W-1:0]    sy;
  logic [POS_W-1:0]    x0;
  logic                draw_ok;
  logic                in_acc;

  cmbe_ad_ctl_t        ad_ctl;
  logic [AW-1:0]       mem_addr;
  logic                ad_done;
  logic                mem_we, mem_re;
  cmbe_em_cmd_t        em_cmd;
  cmbe_em_stat_t       em_stat;

  // --- configuration writes ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCR_W_RST;
      scr_h_r <= SCR_H_RST;
      spr_w_r <= SPR_W_RST;
      spr_h_r <= SPR_H_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data[SCR_W-1:0];
        CFG_SPRITE_WIDTH:  spr_w_r <= cfg_data[SPR_W-1:0];
        CFG_SPRITE_HEIGHT: spr_h_r <= cfg_data[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  // stride = ceil(width / 8)
  assign stride_sum = {1'b0, spr_w_r} + (SPR_W+1)'(7);
  assign stride     = stride_sum[SPR_W:3];

  // screen line and left screen column of this block
  assign sy = {in_bus.origin_y[ORG_W-1], in_bus.origin_y} + POS_W'(in_bus.sprite_row);
  assign x0 = {in_bus.origin_x[ORG_W-1], in_bus.origin_x}
              + POS_W'({in_bus.byte_block, 3'b000});

  // whole-beat rejects: empty sprite, row/block out of range, line off screen
  assign draw_ok = (spr_w_r != '0) && (spr_h_r != '0)
                   && (SPR_W'(in_bus.sprite_row) < spr_h_r)
                   && (STRIDE_W'(in_bus.byte_block) < stride)
                   && !sy[POS_W-1]
                   && (sy[POS_W-2:0] < {1'b0, scr_h_r});

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  assign ad_ctl.start = in_acc && ((in_bus.kind == KIND_LOAD) || draw_ok);
  assign ad_ctl.draw  = (in_bus.kind == KIND_DRAW);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (state_r)
      S_IDLE: if (ad_ctl.start) state_nxt = S_ADDR;
      S_ADDR: begin
        if (ad_done) begin
          if (kind_r == KIND_LOAD) begin
            mem_we    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_EMIT;
      S_EMIT: if (!em_stat.busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // beat fields held for the address and scan phases
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_bus.kind;
      byte_r  <= in_bus.mask_byte;
      y_r     <= sy[SCR_W-1:0];
      x0_r    <= x0;
      col0_r  <= {in_bus.byte_block, 3'b000};
      color_r <= in_bus.paint_color;
    end
  end

  // mask store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_addr] <= byte_r;
    end
    if (mem_re) begin
      rd_byte_r <= mask_mem[mem_addr];
    end
  end

  cmbe_addr_seq #(
    .MASK_BYTES (MASK_BYTES)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ad_ctl),
    .frame_i  (in_bus.frame_index),
    .row_i    (in_bus.sprite_row),
    .block_i  (in_bus.byte_block),
    .maddr_i  (in_bus.mask_address),
    .sh_i     (spr_h_r),
    .stride_i (stride),
    .addr_o   (mem_addr),
    .done_o   (ad_done)
  );

  assign em_cmd.start = (state_r == S_READ);
  assign em_cmd.bits  = rd_byte_r;
  assign em_cmd.col0  = col0_r;
  assign em_cmd.x0    = x0_r;
  assign em_cmd.y     = y_r;
  assign em_cmd.color = color_r;

  cmbe_pix_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (em_cmd),
    .sw_i    (spr_w_r),
    .scr_w_i (scr_w_r),
    .stat    (em_stat),
    .out_bus (out_bus)
  );

  a_done_in_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ad_done |-> (state_r == S_ADDR))
    else $error("address done outside address phase");

  a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !em_stat.busy)
    else $error("pixel scan busy while accepting beats");

endmodule
